/* design/bic_pkg.sv */
// Shared constants, field layouts and types of the binarized im2col packer.
`default_nettype none
package bic_pkg;

  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_WIDTH    = 64;

  localparam int KERNEL_SIZE = 3;
  localparam int KERNEL_AREA = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PAD         = KERNEL_SIZE / 2;

  // Division of the kernel position by the kernel area as a scaled reciprocal.
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP       = (2 ** RECIP_SHIFT + KERNEL_AREA - 1) / KERNEL_AREA;

  localparam int CHAN_W     = 6;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int PIXEL_W    = 32;
  localparam int KPOS_W     = 10;
  localparam int CIM_W      = 7;
  localparam int REM_W      = 4;
  localparam int DIM_W      = 7;
  localparam int PITCH_W    = 16;
  localparam int OFFS_W     = 26;
  localparam int PROD_ROW_W = ROW_W + DIM_W;
  localparam int PACKED_W   = 64;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 96;

  localparam int CHAN_LSB  = 0;
  localparam int ROW_LSB   = CHAN_LSB + CHAN_W;
  localparam int COL_LSB   = ROW_LSB + ROW_W;
  localparam int PIXEL_LSB = COL_LSB + COL_W;
  localparam int KPOS_LSB  = PIXEL_LSB + PIXEL_W;
  localparam int M_USED_W  = PACKED_W + OFFS_W;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH_BITS = 8'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [DIM_W-1:0]   RST_CHANNEL_COUNT  = 7'd1;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT   = 7'd64;
  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH    = 7'd64;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH_BITS = 16'd4096;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC
  } bic_state_t;

endpackage
`default_nettype wire

/* design/bic_sign_store.sv */
// Sign bit store: one word per channel and image row, one read and one write port.
`default_nettype none
module bic_sign_store import bic_pkg::*; #(
  parameter int DEPTH = DEF_MAX_CHANNELS * DEF_MAX_HEIGHT,
  parameter int W     = DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [W-1:0]             rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [W-1:0]             wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* design/binary_im2col_packer_top.sv */
// Top level of the binarized im2col packer for a 3x3 kernel, stride 1, padding 1.
`default_nettype none
// Every request, load or emit, is handled in order: it is accepted, then its store
// address is decoded and the sign store is read, then the word is written back
// (load) or the packed row is placed in the output register (emit). A new request
// is accepted in the cycle after that, so no request is taken while another is in
// flight; the sign store has a registered read, and a load writes back the word that
// it read. An emit also waits in its last step while an earlier result is still held
// in the output register. The store is not cleared after reset, so a row must be
// loaded before it is emitted.
module binary_im2col_packer_top import bic_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // channel, row, column, pixel_bits, kernel_pos, zero fill
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  // command
  input  wire logic                   s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // packed_bits, bit_offset, zero fill
  output logic      [M_TDATA_W-1:0]   m_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int W     = MAX_WIDTH;

  bic_state_t state, state_next;

  logic [DIM_W-1:0]   channel_count;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   image_width;
  logic [PITCH_W-1:0] row_pitch_bits;

  logic                  cmd;
  logic [CHAN_W-1:0]     chan;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      col;
  logic [KPOS_W-1:0]     kpos;
  logic                  pos;
  logic [CIM_W-1:0]      cim;
  logic [OFFS_W-1:0]     prod_pitch;
  logic [PROD_ROW_W-1:0] prod_row;

  logic [1:0]        kx;
  logic              hit;
  logic              load_ok;
  logic [AW-1:0]     wr_addr;
  logic [OFFS_W-1:0] offset;

  logic [PACKED_W-1:0] out_bits;
  logic [OFFS_W-1:0]   out_offset;

  logic [DIM_W-1:0] ww;
  logic             accept;
  logic             out_load;
  logic [31:0]      cim_prod;

  logic [1:0]    kx_d;
  logic          hit_d;
  logic          load_ok_d;
  logic [AW-1:0] rd_addr;

  logic [W-1:0] rd_data;
  logic [W-1:0] wr_data;
  logic [W-1:0] word;

  logic [PIXEL_W-1:0] s_pixel;
  logic               s_positive;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ww        = (32'(image_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width;
  assign m_tdata   = {{(M_TDATA_W - M_USED_W){1'b0}}, out_offset, out_bits};

  assign s_pixel    = s_tdata[PIXEL_LSB +: PIXEL_W];
  assign s_positive = !s_pixel[31] && (s_pixel != 32'h0) && (s_pixel <= 32'h7f80_0000);
  assign cim_prod   = 32'(s_tdata[KPOS_LSB +: KPOS_W]) * 32'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= RST_CHANNEL_COUNT;
      image_height   <= RST_IMAGE_HEIGHT;
      image_width    <= RST_IMAGE_WIDTH;
      row_pitch_bits <= RST_ROW_PITCH_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_ROW_PITCH_BITS: row_pitch_bits <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd == CMD_LOAD) begin
          state_next = S_IDLE;
        end else if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tuser;
      chan       <= s_tdata[CHAN_LSB +: CHAN_W];
      row        <= s_tdata[ROW_LSB +: ROW_W];
      col        <= s_tdata[COL_LSB +: COL_W];
      kpos       <= s_tdata[KPOS_LSB +: KPOS_W];
      pos        <= s_positive;
      cim        <= cim_prod[RECIP_SHIFT +: CIM_W];
      prod_pitch <= OFFS_W'(s_tdata[KPOS_LSB +: KPOS_W]) * OFFS_W'(row_pitch_bits);
      prod_row   <= PROD_ROW_W'(s_tdata[ROW_LSB +: ROW_W]) * PROD_ROW_W'(ww);
    end
  end

  always_comb begin
    logic [KPOS_W-1:0] base;
    logic [KPOS_W-1:0] rem_full;
    logic [REM_W-1:0]  rem;
    logic [1:0]        ky;
    int                ir;
    int                addr_i;
    base     = KPOS_W'(32'(cim) * KERNEL_AREA);
    rem_full = kpos - base;
    rem      = rem_full[REM_W-1:0];
    if (32'(rem) >= 2 * KERNEL_SIZE) begin
      ky = 2'd2;
    end else if (32'(rem) >= KERNEL_SIZE) begin
      ky = 2'd1;
    end else begin
      ky = 2'd0;
    end
    kx_d = 2'(32'(rem) - KERNEL_SIZE * 32'(ky));
    ir   = int'(row) + int'(ky) - PAD;
    hit_d = (int'(row) < int'(image_height)) && (int'(row) < MAX_HEIGHT) &&
            (int'(cim) < int'(channel_count)) && (int'(cim) < MAX_CHANNELS) &&
            (ir >= 0) && (ir < int'(image_height)) && (ir < MAX_HEIGHT);
    load_ok_d = (int'(chan) < MAX_CHANNELS) && (int'(row) < MAX_HEIGHT) &&
                (int'(col) < MAX_WIDTH);
    if (cmd == CMD_EMIT) begin
      addr_i = int'(cim) * MAX_HEIGHT + ir;
    end else begin
      addr_i = int'(chan) * MAX_HEIGHT + int'(row);
    end
    rd_addr = addr_i[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      kx      <= kx_d;
      hit     <= hit_d;
      load_ok <= load_ok_d;
      wr_addr <= rd_addr;
      offset  <= prod_pitch + OFFS_W'(prod_row);
    end
  end

  always_comb begin
    logic [W:0]   one_sh;
    logic [W:0]   mask_full;
    logic [W-1:0] wmask;
    logic [W-1:0] r;
    logic [W-1:0] bit_mask;
    one_sh    = {{W{1'b0}}, 1'b1} << ww;
    mask_full = one_sh - {{W{1'b0}}, 1'b1};
    wmask     = mask_full[W-1:0];
    r         = rd_data & wmask;
    case (kx)
      2'd0:    word = r << 1;
      2'd1:    word = r;
      2'd2:    word = r >> 1;
      default: word = '0;
    endcase
    word = hit ? (word & wmask) : '0;
    bit_mask = {{(W-1){1'b0}}, 1'b1} << col;
    wr_data  = pos ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
  end

  bic_sign_store #(
    .DEPTH(DEPTH),
    .W    (W)
  ) u_store (
    .clk    (clk),
    .rd_en  (state == S_DECODE),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  ((state == S_EXEC) && (cmd == CMD_LOAD) && load_ok),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bits   <= PACKED_W'(word);
      out_offset <= offset;
    end
  end

endmodule
`default_nettype wire

/* design/bic_checker.sv */
// Port-level checks of the binarized im2col packer and their binding to the top level.
`default_nettype none
module bic_checker import bic_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("request taken while another is in flight");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_LOAD) && !m_tvalid |=> ##2 !m_tvalid)
    else $error("load request produced a result");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:M_USED_W] == '0))
    else $error("nonzero fill bits in result");

endmodule

bind binary_im2col_packer_top bic_checker u_bic_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
